// File: rtl/ippp_pkg.sv
// Shared types, constants and binary32 arithmetic helpers for the pair potential core.
`timescale 1ns / 1ps
`default_nettype none
package ippp_pkg;

   // Pipeline geometry
   localparam int DIV_STEPS  = 4;    // quotient bits per divider stage
   localparam int DIV_STAGES = 7;    // 28 quotient bits in total
   localparam int POW_MAX    = 14;   // highest power of 1/x that is ever needed

   localparam logic [31:0] QNAN = 32'h7FC0_0000;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_MODE = 2'd0;
   localparam logic [1:0] CSR_REP  = 2'd1;
   localparam logic [1:0] CSR_ATT  = 2'd2;

   // Exponent pair codes
   localparam logic [2:0] MODE_12_6  = 3'd0;
   localparam logic [2:0] MODE_9_6   = 3'd1;
   localparam logic [2:0] MODE_6_4   = 3'd2;
   localparam logic [2:0] MODE_12_4  = 3'd3;
   localparam logic [2:0] MODE_12_10 = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_DIST = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // binary32 bit patterns of the integer factors
   localparam logic [31:0] F_4   = 32'h4080_0000;
   localparam logic [31:0] F_6   = 32'h40C0_0000;
   localparam logic [31:0] F_9   = 32'h4110_0000;
   localparam logic [31:0] F_10  = 32'h4120_0000;
   localparam logic [31:0] F_12  = 32'h4140_0000;
   localparam logic [31:0] F_20  = 32'h41A0_0000;
   localparam logic [31:0] F_42  = 32'h4228_0000;
   localparam logic [31:0] F_90  = 32'h42B4_0000;
   localparam logic [31:0] F_110 = 32'h42DC_0000;
   localparam logic [31:0] F_156 = 32'h431C_0000;

   // Control bits that travel with each item
   typedef struct packed {
      logic valid;
      logic bad;
   } ctl_type;

   // Decoded exponent pair
   typedef struct packed {
      logic [3:0]  n;
      logic [3:0]  m;
      logic [31:0] n_f;
      logic [31:0] m_f;
      logic [31:0] nn_f;   // n(n+1)
      logic [31:0] mm_f;   // m(m+1)
   } mode_type;

   // Divider state: value of 1/x is built one quotient bit per step
   typedef struct packed {
      logic [23:0] m;
      logic [9:0]  ex;
      logic [24:0] rem;
      logic [27:0] q;
   } div_type;

   // Product before normalize and round; value = prod / 2^46 * 2^exp
   typedef struct packed {
      logic        sgn;
      logic [9:0]  exp;
      logic [47:0] prod;
      logic        zero;
      logic        nonfin;
   } mulraw_type;

   // Difference before normalize and round; value = sum / 2^26 * 2^exp
   typedef struct packed {
      logic        sgn;
      logic [9:0]  exp;
      logic [27:0] sum;
      logic        zsgn;
      logic        nonfin;
   } addraw_type;

   function automatic mode_type mode_decode(input logic [2:0] mode);
      mode_type d;
      unique case (mode)
         MODE_9_6:   d = '{n: 4'd9,  m: 4'd6,  n_f: F_9,  m_f: F_6,  nn_f: F_90,  mm_f: F_42};
         MODE_6_4:   d = '{n: 4'd6,  m: 4'd4,  n_f: F_6,  m_f: F_4,  nn_f: F_42,  mm_f: F_20};
         MODE_12_4:  d = '{n: 4'd12, m: 4'd4,  n_f: F_12, m_f: F_4,  nn_f: F_156, mm_f: F_20};
         MODE_12_10: d = '{n: 4'd12, m: 4'd10, n_f: F_12, m_f: F_10, nn_f: F_156, mm_f: F_110};
         default:    d = '{n: 4'd12, m: 4'd6,  n_f: F_12, m_f: F_6,  nn_f: F_156, mm_f: F_42};
      endcase
      return d;
   endfunction

   // Leading zero count, 48 for an all-zero word
   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       hit;
      n   = '0;
      hit = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!hit) begin
            if (v[i]) hit = 1'b1;
            else      n   = n + 6'd1;
         end
      end
      return n;
   endfunction

   // Unbiased exponent of a field, subnormals at -126 (two's complement)
   function automatic logic [9:0] exp_unb(input logic [7:0] f);
      return (f == 8'd0) ? 10'h382 : ({2'b00, f} - 10'd127);
   endfunction

   // Round to nearest even and pack. sig[26] is the leading one,
   // value = sig / 2^26 * 2^e, sig[0] carries the sticky bit.
   function automatic logic [31:0] round_pack(input logic sgn, input logic [9:0] e,
                                              input logic [26:0] sig);
      logic [9:0]  be;
      logic [9:0]  sh;
      logic [26:0] sv;
      logic        inc;
      logic [24:0] m;
      logic [8:0]  bexp;
      logic [31:0] res;
      be = e + 10'd127;
      sh = 10'd1 - be;
      if ($signed(be) >= 10'sd1) begin
         sv = sig;
      end else if (sh >= 10'd27) begin
         sv = {26'd0, |sig};
      end else begin
         sv = (sig >> sh) | {26'd0, |(sig & ~(27'h7FF_FFFF << sh))};
      end
      inc = sv[2] & (sv[3] | (|sv[1:0]));
      m   = {1'b0, sv[26:3]} + {24'd0, inc};
      if ($signed(be) >= 10'sd1) begin
         bexp = be[8:0] + {8'd0, m[24]};
         if (bexp >= 9'd255) res = {sgn, 8'hFF, 23'd0};
         else                res = {sgn, bexp[7:0], (m[24] ? m[23:1] : m[22:0])};
      end else begin
         // subnormal; a carry into the hidden bit yields the smallest normal
         res = {sgn, 7'd0, m[23], m[22:0]};
      end
      return res;
   endfunction

   function automatic mulraw_type fmul_raw(input logic [31:0] a, input logic [31:0] b);
      mulraw_type r;
      logic [23:0] sa;
      logic [23:0] sb;
      sa       = {a[30:23] != 8'd0, a[22:0]};
      sb       = {b[30:23] != 8'd0, b[22:0]};
      r.sgn    = a[31] ^ b[31];
      r.exp    = exp_unb(a[30:23]) + exp_unb(b[30:23]);
      r.prod   = {24'd0, sa} * {24'd0, sb};
      r.zero   = (a[30:0] == 31'd0) || (b[30:0] == 31'd0);
      r.nonfin = (&a[30:23]) | (&b[30:23]);
      return r;
   endfunction

   function automatic logic [31:0] fmul_fin(input mulraw_type r);
      logic [5:0]  lz;
      logic [47:0] p;
      logic [9:0]  e;
      logic [31:0] res;
      lz = lzc48(r.prod);
      p  = r.prod << lz;
      e  = r.exp + 10'd1 - {4'd0, lz};
      if (r.nonfin)    res = QNAN;
      else if (r.zero) res = {r.sgn, 31'd0};
      else             res = round_pack(r.sgn, e, {p[47:22], |p[21:0]});
      return res;
   endfunction

   // a - b: order by magnitude, align with sticky, add or subtract
   function automatic addraw_type fsub_raw(input logic [31:0] a, input logic [31:0] b);
      addraw_type r;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] t;
      logic [7:0]  ex;
      logic [7:0]  ey;
      logic [7:0]  d;
      logic [26:0] lx;
      logic [26:0] sy;
      logic [26:0] ss;
      x = a;
      y = {~b[31], b[30:0]};
      if (x[30:0] < y[30:0]) begin
         t = x;
         x = y;
         y = t;
      end
      ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      d  = ex - ey;
      lx = {x[30:23] != 8'd0, x[22:0], 3'b000};
      sy = {y[30:23] != 8'd0, y[22:0], 3'b000};
      if (d >= 8'd27) ss = {26'd0, |sy};
      else            ss = (sy >> d) | {26'd0, |(sy & ~(27'h7FF_FFFF << d))};
      if (x[31] == y[31]) r.sum = {1'b0, lx} + {1'b0, ss};
      else                r.sum = {1'b0, lx} - {1'b0, ss};
      r.sgn    = x[31];
      r.exp    = {2'b00, ex} - 10'd127;
      r.zsgn   = a[31] & ~b[31];
      r.nonfin = (&a[30:23]) | (&b[30:23]);
      return r;
   endfunction

   function automatic logic [31:0] fsub_fin(input addraw_type r);
      logic [5:0]  lz;
      logic [27:0] p;
      logic [9:0]  e;
      logic [31:0] res;
      lz = lzc48({r.sum, 20'd0});
      p  = r.sum << lz;
      e  = r.exp + 10'd1 - {4'd0, lz};
      if (r.nonfin)              res = QNAN;
      else if (r.sum == 28'd0)   res = {r.zsgn, 31'd0};
      else                       res = round_pack(r.sgn, e, {p[27:2], |p[1:0]});
      return res;
   endfunction

   // DIV_STEPS restoring steps of the reciprocal
   function automatic div_type div_step(input div_type s);
      div_type t;
      t = s;
      for (int i = 0; i < DIV_STEPS; i++) begin
         if (t.rem >= {1'b0, t.m}) begin
            t.rem = t.rem - {1'b0, t.m};
            t.q   = {t.q[26:0], 1'b1};
         end else begin
            t.q   = {t.q[26:0], 1'b0};
         end
         t.rem = {t.rem[23:0], 1'b0};
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// File: rtl/ippp_recip.sv
// Pipelined reciprocal 1/x in binary32: normalize, restoring divide, round.
`timescale 1ns / 1ps
`default_nettype none
module ippp_recip (
   input  logic             clock,
   input  logic             reset,
   input  ippp_pkg::ctl_type in_ctl,
   input  logic [31:0]      in_x,
   output ippp_pkg::ctl_type out_ctl,
   output logic [31:0]      out_r
);
   import ippp_pkg::*;

   ctl_type [DIV_STAGES+1:0] ctl_ff;
   ctl_type [DIV_STAGES+1:0] ctl_in;
   div_type                  div_ff [DIV_STAGES+1];
   div_type                  div_in;
   logic [31:0]              r_ff;
   logic [31:0]              r_in;
   logic [23:0]              m24;
   logic [5:0]               lz;
   logic                     sticky;

   // Normalize x so the divisor has its leading one at bit 23
   always_comb begin
      m24        = {in_x[30:23] != 8'd0, in_x[22:0]};
      lz         = lzc48({m24, 24'd0});
      div_in.m   = m24 << lz;
      div_in.ex  = exp_unb(in_x[30:23]) - {4'd0, lz};
      div_in.rem = 25'h080_0000;   // 1.0 in divisor units
      div_in.q   = '0;
   end

   // Quotient 1/mx with 28 bits, then round
   always_comb begin
      sticky = |div_ff[DIV_STAGES].rem;
      if (div_ff[DIV_STAGES].q[27]) begin
         r_in = round_pack(1'b0, 10'd0 - div_ff[DIV_STAGES].ex,
                           {div_ff[DIV_STAGES].q[27:2], (|div_ff[DIV_STAGES].q[1:0]) | sticky});
      end else begin
         r_in = round_pack(1'b0, 10'd0 - div_ff[DIV_STAGES].ex - 10'd1,
                           {div_ff[DIV_STAGES].q[26:1], div_ff[DIV_STAGES].q[0] | sticky});
      end
   end

   assign ctl_in = {ctl_ff[DIV_STAGES:0], in_ctl};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      div_ff[0] <= div_in;
      for (int j = 1; j <= DIV_STAGES; j++) begin
         div_ff[j] <= div_step(div_ff[j-1]);
      end
      r_ff <= r_in;
   end

   assign out_ctl = ctl_ff[DIV_STAGES+1];
   assign out_r   = r_ff;

endmodule
`default_nettype wire

// File: rtl/ippp_powers.sv
// Chain of multiplier stages that forms the powers of 1/x and keeps those the mode needs.
`timescale 1ns / 1ps
`default_nettype none
module ippp_powers (
   input  logic             clock,
   input  logic             reset,
   input  logic [2:0]       mode,
   input  ippp_pkg::ctl_type in_ctl,
   input  logic [31:0]      in_r,
   output ippp_pkg::ctl_type out_ctl,
   output logic [31:0]      out_pn,
   output logic [31:0]      out_pm,
   output logic [31:0]      out_pn2,
   output logic [31:0]      out_pm2
);
   import ippp_pkg::*;

   localparam int DEPTH = 2 * POW_MAX - 1;

   typedef struct packed {
      logic [31:0] r;
      logic [31:0] p;
      logic [31:0] pn;
      logic [31:0] pm;
      logic [31:0] pn2;
      logic [31:0] pm2;
   } pow_type;

   typedef struct packed {
      logic [31:0] r;
      logic [31:0] pn;
      logic [31:0] pm;
      logic [31:0] pn2;
      logic [31:0] pm2;
      mulraw_type  prod;
   } powraw_type;

   ctl_type [DEPTH-1:0] ctl_ff;
   ctl_type [DEPTH-1:0] ctl_in;
   pow_type             full_ff [1:POW_MAX];
   powraw_type          raw_ff  [2:POW_MAX];
   mode_type            md;
   logic [31:0]         p_new   [2:POW_MAX];

   assign md = mode_decode(mode);

   always_comb begin
      for (int k = 2; k <= POW_MAX; k++) begin
         p_new[k] = fmul_fin(raw_ff[k].prod);
      end
   end

   assign ctl_in = {ctl_ff[DEPTH-2:0], in_ctl};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // p[k] = p[k-1] * r, one product and one round per stage
   always_ff @(posedge clock) begin
      full_ff[1] <= '{r: in_r, p: in_r, pn: '0, pm: '0, pn2: '0, pm2: '0};
      for (int k = 2; k <= POW_MAX; k++) begin
         raw_ff[k].r    <= full_ff[k-1].r;
         raw_ff[k].pn   <= full_ff[k-1].pn;
         raw_ff[k].pm   <= full_ff[k-1].pm;
         raw_ff[k].pn2  <= full_ff[k-1].pn2;
         raw_ff[k].pm2  <= full_ff[k-1].pm2;
         raw_ff[k].prod <= fmul_raw(full_ff[k-1].p, full_ff[k-1].r);
         full_ff[k].r   <= raw_ff[k].r;
         full_ff[k].p   <= p_new[k];
         full_ff[k].pn  <= (4'(k) == md.n)        ? p_new[k] : raw_ff[k].pn;
         full_ff[k].pm  <= (4'(k) == md.m)        ? p_new[k] : raw_ff[k].pm;
         full_ff[k].pn2 <= (4'(k) == md.n + 4'd2) ? p_new[k] : raw_ff[k].pn2;
         full_ff[k].pm2 <= (4'(k) == md.m + 4'd2) ? p_new[k] : raw_ff[k].pm2;
      end
   end

   assign out_ctl = ctl_ff[DEPTH-1];
   assign out_pn  = full_ff[POW_MAX].pn;
   assign out_pm  = full_ff[POW_MAX].pm;
   assign out_pn2 = full_ff[POW_MAX].pn2;
   assign out_pm2 = full_ff[POW_MAX].pm2;

endmodule
`default_nettype wire

// File: rtl/ippp_combine.sv
// Coefficient products, term products and the three differences.
`timescale 1ns / 1ps
`default_nettype none
module ippp_combine (
   input  logic             clock,
   input  logic             reset,
   input  logic [2:0]       mode,
   input  logic [31:0]      coef_a,
   input  logic [31:0]      coef_b,
   input  ippp_pkg::ctl_type in_ctl,
   input  logic [31:0]      in_pn,
   input  logic [31:0]      in_pm,
   input  logic [31:0]      in_pn2,
   input  logic [31:0]      in_pm2,
   output ippp_pkg::ctl_type out_ctl,
   output logic [31:0]      out_energy,
   output logic [31:0]      out_force,
   output logic [31:0]      out_curv
);
   import ippp_pkg::*;

   localparam int TERMS = 6;
   localparam int DIFFS = 3;

   mode_type      md;
   ctl_type [3:0] ctl_ff;
   ctl_type [3:0] ctl_in;
   // n*A, m*B, n(n+1)*A, m(m+1)*B; follow the registers at all times
   mulraw_type    craw_ff [4];
   logic [31:0]   coef_ff [4];
   logic [31:0]   op_l    [TERMS];
   logic [31:0]   op_r    [TERMS];
   mulraw_type    traw_ff [TERMS];
   logic [31:0]   term_ff [TERMS];
   addraw_type    draw_ff [DIFFS];
   logic [31:0]   diff_ff [DIFFS];

   assign md = mode_decode(mode);

   // Operand pairs of the six term products
   always_comb begin
      op_l[0] = coef_a;      op_r[0] = in_pn;
      op_l[1] = coef_b;      op_r[1] = in_pm;
      op_l[2] = coef_ff[1];  op_r[2] = in_pm2;
      op_l[3] = coef_ff[0];  op_r[3] = in_pn2;
      op_l[4] = coef_ff[2];  op_r[4] = in_pn2;
      op_l[5] = coef_ff[3];  op_r[5] = in_pm2;
   end

   assign ctl_in = {ctl_ff[2:0], in_ctl};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      craw_ff[0] <= fmul_raw(md.n_f, coef_a);
      craw_ff[1] <= fmul_raw(md.m_f, coef_b);
      craw_ff[2] <= fmul_raw(md.nn_f, coef_a);
      craw_ff[3] <= fmul_raw(md.mm_f, coef_b);
      for (int i = 0; i < 4; i++) begin
         coef_ff[i] <= fmul_fin(craw_ff[i]);
      end
      for (int i = 0; i < TERMS; i++) begin
         traw_ff[i] <= fmul_raw(op_l[i], op_r[i]);
         term_ff[i] <= fmul_fin(traw_ff[i]);
      end
      for (int i = 0; i < DIFFS; i++) begin
         draw_ff[i] <= fsub_raw(term_ff[2*i], term_ff[2*i+1]);
         diff_ff[i] <= fsub_fin(draw_ff[i]);
      end
   end

   assign out_ctl    = ctl_ff[3];
   assign out_energy = diff_ff[0];
   assign out_force  = diff_ff[1];
   assign out_curv   = diff_ff[2];

endmodule
`default_nettype wire

// File: rtl/inverse_power_pair_potential_core.sv
// Top level of the n-m inverse-power pair potential core.
//
// Usage:
//  - Configuration: csr_valid/csr_ready write channel, csr_index selects
//    0 exponent mode, 1 repulsive coefficient A, 2 attractive coefficient B.
//    csr_ready is always high; index 3 is ignored. Write only while idle.
//  - Input: one binary32 distance per transfer, taken at a rising edge with
//    start high and busy low. busy stays low: a new distance may enter
//    every clock cycle.
//  - Output: rsp_valid is high for one cycle with energy, force over r,
//    curvature and status. The receiver cannot stall the block.
//  - Pipeline: 41 register stages in all, the output register included:
//    9 in the reciprocal (normalize, seven radix-2 divider stages of four
//    bits each, round), 27 in the power chain (thirteen multiply-round
//    pairs behind one entry register), 4 in the product and difference
//    stages and 1 output register.
//  - Throughput: one item per cycle; every stage advances each cycle.
//  - Reset empties the pipeline and zeroes the configuration, not the data.
`timescale 1ns / 1ps
`default_nettype none
module inverse_power_pair_potential_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_distance,
   output logic        rsp_valid,
   output logic [31:0] rsp_energy,
   output logic [31:0] rsp_force_over_r,
   output logic [31:0] rsp_curvature,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ippp_pkg::*;

   logic [2:0]  mode_ff;
   logic [31:0] rep_ff;
   logic [31:0] att_ff;
   ctl_type     in_ctl;
   ctl_type     rcp_ctl;
   ctl_type     pow_ctl;
   ctl_type     cmb_ctl;
   logic [31:0] rcp_r;
   logic [31:0] pn;
   logic [31:0] pm;
   logic [31:0] pn2;
   logic [31:0] pm2;
   logic [31:0] energy;
   logic [31:0] force_r;
   logic [31:0] curv;
   logic        ovf;
   logic        valid_ff;
   logic [31:0] energy_ff;
   logic [31:0] force_ff;
   logic [31:0] curv_ff;
   logic [1:0]  status_ff;
   logic [31:0] energy_in;
   logic [31:0] force_in;
   logic [31:0] curv_in;
   logic [1:0]  status_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         rep_ff  <= '0;
         att_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE: mode_ff <= csr_data[2:0];
            CSR_REP:  rep_ff  <= csr_data;
            CSR_ATT:  att_ff  <= csr_data;
            default:  ;
         endcase
      end
   end

   // Negative, zero, infinite or NaN distance
   assign in_ctl.valid = start;
   assign in_ctl.bad   = req_distance[31] || (req_distance[30:0] == 31'd0) ||
                         (&req_distance[30:23]);

   ippp_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (in_ctl),
      .in_x    (req_distance),
      .out_ctl (rcp_ctl),
      .out_r   (rcp_r)
   );

   ippp_powers u_powers (
      .clock   (clock),
      .reset   (reset),
      .mode    (mode_ff),
      .in_ctl  (rcp_ctl),
      .in_r    (rcp_r),
      .out_ctl (pow_ctl),
      .out_pn  (pn),
      .out_pm  (pm),
      .out_pn2 (pn2),
      .out_pm2 (pm2)
   );

   ippp_combine u_combine (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .coef_a     (rep_ff),
      .coef_b     (att_ff),
      .in_ctl     (pow_ctl),
      .in_pn      (pn),
      .in_pm      (pm),
      .in_pn2     (pn2),
      .in_pm2     (pm2),
      .out_ctl    (cmb_ctl),
      .out_energy (energy),
      .out_force  (force_r),
      .out_curv   (curv)
   );

   // Status and zeroing of flagged results
   always_comb begin
      ovf = (&energy[30:23]) | (&force_r[30:23]) | (&curv[30:23]);
      if (cmb_ctl.bad) begin
         status_in = STATUS_BAD_DIST;
         energy_in = '0;
         force_in  = '0;
         curv_in   = '0;
      end else if (ovf) begin
         status_in = STATUS_OVERFLOW;
         energy_in = '0;
         force_in  = '0;
         curv_in   = '0;
      end else begin
         status_in = STATUS_OK;
         energy_in = energy;
         force_in  = force_r;
         curv_in   = curv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmb_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      energy_ff <= energy_in;
      force_ff  <= force_in;
      curv_ff   <= curv_in;
      status_ff <= status_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_energy       = energy_ff;
   assign rsp_force_over_r = force_ff;
   assign rsp_curvature    = curv_ff;
   assign rsp_status       = status_ff;

endmodule
`default_nettype wire

// File: tb/sv/inverse_power_pair_potential_core_tb.sv
// Self-checking testbench for the n-m inverse-power pair potential core.
`timescale 1ns / 1ps
module inverse_power_pair_potential_core_tb;
   import ippp_pkg::*;

   localparam int LATENCY = 41;

   typedef struct packed {
      logic [31:0] energy;
      logic [31:0] force_over_r;
      logic [31:0] curvature;
      logic [1:0]  status;
   } potential_type;

   // binary32 arithmetic, round to nearest even, wide integer significands
   function automatic void unpack_f32(input logic [31:0] v, output logic [23:0] mant,
                                      output int ex);
      if (v[30:23] == 8'd0) begin
         mant = {1'b0, v[22:0]};
         ex   = -149;
      end else begin
         mant = {1'b1, v[22:0]};
         ex   = int'(v[30:23]) - 150;
      end
   endfunction

   // value = mag * 2^e2, stk marks nonzero bits below mag
   function automatic logic [31:0] round_f32(input logic sgn, input int e2,
                                             input logic [299:0] mag, input logic stk);
      int          msb;
      int          lsb;
      int          sh;
      logic [299:0] keep;
      logic        half;
      logic        low;
      msb = -1;
      for (int i = 0; i < 300; i++) if (mag[i]) msb = i;
      if (msb < 0) return {sgn, 31'd0};
      lsb = (msb + e2 >= -126) ? msb + e2 - 23 : -149;
      sh  = lsb - e2;
      if (sh <= 0) begin
         keep = mag << (-sh);
         half = 1'b0;
         low  = stk;
      end else if (sh >= 300) begin
         keep = '0;
         half = 1'b0;
         low  = 1'b1;
      end else begin
         keep = mag >> sh;
         half = mag[sh-1];
         low  = stk | ((mag & ((300'd1 << (sh - 1)) - 300'd1)) != '0);
      end
      if (half && (low || keep[0])) keep = keep + 300'd1;
      if (keep[24]) begin
         keep = keep >> 1;
         lsb++;
      end
      if (lsb > 104) return {sgn, 8'hFF, 23'd0};
      if (lsb == -149 && !keep[23]) return {sgn, 8'h00, keep[22:0]};
      return {sgn, 8'(lsb + 150), keep[22:0]};
   endfunction

   function automatic logic is_nonfinite(input logic [31:0] v);
      return &v[30:23];
   endfunction

   function automatic logic [31:0] int_to_f32(input int k);
      return round_f32(1'b0, 0, 300'(k), 1'b0);
   endfunction

   // non-finite inputs collapse to NaN: only finiteness of them matters
   function automatic logic [31:0] mul_f32(input logic [31:0] a, input logic [31:0] b);
      logic [23:0] ma;
      logic [23:0] mb;
      int          ea;
      int          eb;
      if (is_nonfinite(a) || is_nonfinite(b)) return 32'h7FC0_0000;
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {a[31] ^ b[31], 31'd0};
      unpack_f32(a, ma, ea);
      unpack_f32(b, mb, eb);
      return round_f32(a[31] ^ b[31], ea + eb, 300'(ma) * 300'(mb), 1'b0);
   endfunction

   function automatic logic [31:0] sub_f32(input logic [31:0] a, input logic [31:0] b);
      logic [23:0]  ma;
      logic [23:0]  mb;
      int           ea;
      int           eb;
      int           emin;
      logic [299:0] va;
      logic [299:0] vb;
      logic [299:0] mag;
      logic         sgn;
      logic         sbn;
      if (is_nonfinite(a) || is_nonfinite(b)) return 32'h7FC0_0000;
      unpack_f32(a, ma, ea);
      unpack_f32(b, mb, eb);
      emin = (ea < eb) ? ea : eb;
      va   = 300'(ma) << (ea - emin);
      vb   = 300'(mb) << (eb - emin);
      sbn  = ~b[31];
      if (a[31] == sbn) begin
         mag = va + vb;
         sgn = a[31];
      end else if (va >= vb) begin
         mag = va - vb;
         sgn = a[31];
      end else begin
         mag = vb - va;
         sgn = sbn;
      end
      if (mag == '0) sgn = a[31] & ~b[31];
      return round_f32(sgn, emin, mag, 1'b0);
   endfunction

   // 1/x for positive finite nonzero x
   function automatic logic [31:0] recip_f32(input logic [31:0] x);
      logic [23:0]  mx;
      int           ex;
      logic [127:0] q;
      logic [127:0] rm;
      unpack_f32(x, mx, ex);
      q  = (128'd1 << 100) / 128'(mx);
      rm = (128'd1 << 100) % 128'(mx);
      return round_f32(1'b0, -100 - ex, 300'(q), rm != '0);
   endfunction

   // Scoreboard: register copy, potential predictor and pending results
   class pair_potential_scoreboard;
      logic [2:0]    mode;
      logic [31:0]   rep_coef;
      logic [31:0]   att_coef;
      potential_type pending[$];
      int            errors;

      function new();
         mode     = '0;
         rep_coef = '0;
         att_coef = '0;
         errors   = 0;
      endfunction

      function void write_reg(input logic [1:0] idx, input logic [31:0] data);
         if (idx == CSR_MODE)     mode     = data[2:0];
         else if (idx == CSR_REP) rep_coef = data;
         else if (idx == CSR_ATT) att_coef = data;
      endfunction

      function potential_type evaluate(input logic [31:0] x);
         potential_type res;
         logic [31:0]   pw[15];
         logic [31:0]   r;
         int            n;
         int            m;
         res = '0;
         case (mode)
            MODE_9_6:   begin n = 9;  m = 6;  end
            MODE_6_4:   begin n = 6;  m = 4;  end
            MODE_12_4:  begin n = 12; m = 4;  end
            MODE_12_10: begin n = 12; m = 10; end
            default:    begin n = 12; m = 6;  end
         endcase
         if (x[31] || x[30:0] == 31'd0 || is_nonfinite(x)) begin
            res.status = STATUS_BAD_DIST;
            return res;
         end
         r     = recip_f32(x);
         pw[0] = 32'h3F80_0000;
         for (int k = 1; k < 15; k++) pw[k] = mul_f32(pw[k-1], r);
         res.energy = sub_f32(mul_f32(rep_coef, pw[n]), mul_f32(att_coef, pw[m]));
         res.force_over_r = sub_f32(
            mul_f32(mul_f32(int_to_f32(m), att_coef), pw[m+2]),
            mul_f32(mul_f32(int_to_f32(n), rep_coef), pw[n+2]));
         res.curvature = sub_f32(
            mul_f32(mul_f32(int_to_f32(n * (n + 1)), rep_coef), pw[n+2]),
            mul_f32(mul_f32(int_to_f32(m * (m + 1)), att_coef), pw[m+2]));
         if (is_nonfinite(res.energy) || is_nonfinite(res.force_over_r)
             || is_nonfinite(res.curvature)) begin
            res = '0;
            res.status = STATUS_OVERFLOW;
         end else begin
            res.status = STATUS_OK;
         end
         return res;
      endfunction

      function void note_distance(input logic [31:0] x);
         pending.push_back(evaluate(x));
      endfunction

      function void check_result(input potential_type got);
         potential_type want;
         if (pending.size() == 0) begin
            $error("unexpected result: energy %h status %0d", got.energy, got.status);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.energy !== want.energy) begin
            $error("energy: expected %h, got %h", want.energy, got.energy);
            errors++;
         end
         if (got.force_over_r !== want.force_over_r) begin
            $error("force_over_r: expected %h, got %h", want.force_over_r, got.force_over_r);
            errors++;
         end
         if (got.curvature !== want.curvature) begin
            $error("curvature: expected %h, got %h", want.curvature, got.curvature);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_distance;
   logic        rsp_valid;
   logic [31:0] rsp_energy;
   logic [31:0] rsp_force_over_r;
   logic [31:0] rsp_curvature;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   pair_potential_scoreboard potentials = new();
   logic idle_enable;

   inverse_power_pair_potential_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_distance(req_distance), .rsp_valid(rsp_valid), .rsp_energy(rsp_energy),
      .rsp_force_over_r(rsp_force_over_r), .rsp_curvature(rsp_curvature),
      .rsp_status(rsp_status), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         potentials.check_result({rsp_energy, rsp_force_over_r, rsp_curvature, rsp_status});
      end
   end

   // Register write transfer; called only while the pipeline is empty
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      potentials.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One distance transfer, with an optional idle burst ahead of it
   task automatic send_distance(input logic [31:0] x);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      start        = 1'b1;
      req_distance = x;
      do @(posedge clock); while (busy);
      potentials.note_distance(x);
      @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      while (potentials.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic set_regs(input logic [31:0] mode_val, input logic [31:0] a,
                           input logic [31:0] b);
      drain();
      write_csr(CSR_MODE, mode_val);
      write_csr(CSR_REP, a);
      write_csr(CSR_ATT, b);
   endtask

   function automatic logic [31:0] rand_coef();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return {1'b0, 8'($urandom_range(100, 160)), 23'($urandom)};
   endfunction

   function automatic logic [31:0] rand_distance();
      if ($urandom_range(0, 6) == 0) return $urandom;
      return {1'b0, 8'($urandom_range(115, 140)), 23'($urandom)};
   endfunction

   // Stimulus
   initial begin
      logic [31:0] edge_dists[13];
      reset        = 1'b1;
      start        = 1'b0;
      req_distance = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      idle_enable  = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes and bad distances, 12-6 with A = B = 4
      edge_dists = '{32'h0000_0000, 32'h8000_0000, 32'hBF80_0000, 32'h7F80_0000,
                     32'hFF80_0000, 32'h7FC0_0000, 32'h3F80_0000, 32'h3F8F_A6AE,
                     32'h0000_0001, 32'h7F7F_FFFF, 32'h4000_0000, 32'h3F00_0000,
                     32'h0080_0000};
      set_regs(MODE_12_6, 32'h4080_0000, 32'h4080_0000);
      foreach (edge_dists[i]) send_distance(edge_dists[i]);
      // every exponent pair, reserved codes included; ignored index
      for (int md = 0; md < 8; md++) begin
         drain();
         write_csr(CSR_MODE, 32'(md));
         send_distance(32'h3FC0_0000);
      end
      drain();
      write_csr(2'd3, 32'hFFFF_FFFF);
      send_distance(32'h3FC0_0000);
      // non-finite coefficients overflow, zero coefficients give zero
      set_regs(MODE_12_6, 32'h7F80_0000, 32'h4080_0000);
      send_distance(32'h3F80_0000);
      set_regs(MODE_12_6, 32'hFFFF_FFFF, 32'h0000_0000);
      send_distance(32'h3F80_0000);
      set_regs(MODE_12_6, 32'h0000_0000, 32'h0000_0000);
      send_distance(32'h3F80_0000);

      // random phases over all modes and coefficient settings
      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 0)      set_regs(32'hFFFF_FFF8, 32'h7F7F_FFFF, 32'h0000_0001);
         else if (ph == 8) set_regs($urandom, rand_coef(), rand_coef());
         else              set_regs(32'(ph - 1) | ($urandom & 32'hFFFF_FFF8),
                                    rand_coef(), rand_coef());
         idle_enable = (ph < 8);
         for (int i = 0; i < 160; i++) send_distance(rand_distance());
      end

      start = 1'b0;
      while (potentials.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (potentials.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
